/* rtl/ddo_pkg.sv */
// Package for the differential-drive odometry block: op codes, sequencer states,
// fixed-point constants, the CORDIC arctangent table and saturation helpers.
// No dependencies.
package ddo_pkg;

    typedef enum logic [1:0] {
        OP_LEFT  = 2'd0,
        OP_RIGHT = 2'd1,
        OP_POSE  = 2'd2,
        OP_TICK  = 2'd3
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SMUL,
        ST_SSAT,
        ST_ARG_MUL,
        ST_ARG_CHK,
        ST_SQ_MUL,
        ST_SQ_INIT,
        ST_SQRT,
        ST_VEC,
        ST_TURN,
        ST_ROT_PREP,
        ST_ROT,
        ST_XMUL,
        ST_XADD,
        ST_YADD,
        ST_LINIT,
        ST_LDIV,
        ST_ADIV,
        ST_OUT
    } state_t;

    // config register indexes
    localparam logic CFG_MPT = 1'b0;
    localparam logic CFG_IWB = 1'b1;

    localparam int CORDIC_STEPS_DEF = 24;

    localparam logic [31:0] MPT_RESET = 32'd1727661;
    localparam logic [23:0] IWB_RESET = 24'd327680;

    localparam logic signed [33:0] ONE_Q28     = 34'sd268435456;
    localparam logic signed [33:0] PI_Q28      = 34'sd843314857;
    localparam logic signed [33:0] TWO_PI_Q28  = 34'sd1686629713;
    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [33:0] US_PER_S    = 34'sd1000000;

    function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
        logic signed [33:0] v;
        case (idx)
            5'd0:  v = 34'sh03243F6A8;
            5'd1:  v = 34'sh01DAC6705;
            5'd2:  v = 34'sh00FADBAFC;
            5'd3:  v = 34'sh007F56EA6;
            5'd4:  v = 34'sh003FEAB76;
            5'd5:  v = 34'sh001FFD55B;
            5'd6:  v = 34'sh000FFFAAA;
            5'd7:  v = 34'sh0007FFF55;
            5'd8:  v = 34'sh0003FFFEA;
            5'd9:  v = 34'sh0001FFFFD;
            5'd10: v = 34'sh0000FFFFF;
            5'd11: v = 34'sh00007FFFF;
            5'd12: v = 34'sh00003FFFF;
            5'd13: v = 34'sh00001FFFF;
            5'd14: v = 34'sh00000FFFF;
            5'd15: v = 34'sh000007FFF;
            5'd16: v = 34'sh000003FFF;
            5'd17: v = 34'sh000001FFF;
            5'd18: v = 34'sh000000FFF;
            5'd19: v = 34'sh0000007FF;
            5'd20: v = 34'sh0000003FF;
            5'd21: v = 34'sh0000001FF;
            5'd22: v = 34'sh0000000FF;
            5'd23: v = 34'sh00000007F;
            5'd24: v = 34'sh00000003F;
            5'd25: v = 34'sh00000001F;
            5'd26: v = 34'sh00000000F;
            5'd27: v = 34'sh000000007;
            5'd28: v = 34'sh000000003;
            5'd29: v = 34'sh000000001;
            default: v = 34'sh0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -68'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // single wrap into +-pi (Q4.28)
    function automatic logic signed [33:0] wrap_once(input logic signed [33:0] v);
        logic signed [33:0] r;
        if (v > PI_Q28) begin
            r = v - TWO_PI_Q28;
        end else if (v < -PI_Q28) begin
            r = v + TWO_PI_Q28;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // signed, saturated speed from an unsigned quotient magnitude
    function automatic logic signed [31:0] rate_sat(input logic [51:0] q, input logic neg);
        logic signed [31:0] r;
        if (neg) begin
            if (q > 52'd2147483648) begin
                r = 32'sh80000000;
            end else begin
                r = -$signed(q[31:0]);
            end
        end else begin
            if (q > 52'd2147483647) begin
                r = 32'sh7FFFFFFF;
            end else begin
                r = $signed(q[31:0]);
            end
        end
        return r;
    endfunction

endpackage

/* rtl/diff_drive_odometry.sv */
// Differential-drive wheel odometry: dead-reckoning pose integrator.
// Requests are taken one at a time: count samples, pose sets, rejected ticks and
//   update ticks each finish before the next request is accepted.
// The tick time is set by the shared multiplier, the 29-step square root, the
//   shared CORDIC stage and two 52-step restoring divisions.
// Synchronous active-low reset clears pose, travels and counts; config to defaults.
module diff_drive_odometry #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_operation,
    input  logic signed [31:0] s_encoder_count,
    input  logic signed [31:0] s_pose_x,
    input  logic signed [31:0] s_pose_y,
    input  logic signed [30:0] s_pose_yaw,
    input  logic [23:0]        s_elapsed_us,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_pos_x,
    output logic signed [31:0] m_pos_y,
    output logic signed [30:0] m_heading,
    output logic signed [31:0] m_linear_speed,
    output logic signed [31:0] m_turn_rate,
    output logic               m_rejected,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_wdata
);

    localparam int ITW = $clog2(CORDIC_STEPS);
    localparam logic [ITW-1:0] ITER_LAST = ITW'(CORDIC_STEPS - 1);
    localparam logic signed [67:0] RND16 = 68'sd32768;
    localparam logic signed [67:0] RND30 = 68'sd536870912;

    ddo_pkg::state_t state_reg, state_next;

    logic [31:0]        mpt_reg;
    logic [23:0]        iwb_reg;
    logic [31:0]        prev_left_reg, prev_right_reg;
    logic signed [31:0] left_reg, right_reg;
    logic signed [31:0] cur_x_reg, cur_y_reg;
    logic signed [30:0] cur_yaw_reg;
    logic               pose_loaded_reg;

    logic signed [31:0] ticks_reg;
    logic               side_reg;
    logic [23:0]        dt_reg;
    logic signed [31:0] dist_reg;
    logic signed [29:0] arg_reg;
    logic signed [31:0] turn_reg;
    logic               neg_reg;
    logic signed [31:0] lin_reg, ang_reg;
    logic               rej_reg;

    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] prod_reg;

    logic [57:0]        rem_reg, res_reg, bit_reg;
    logic [57:0]        sq_sum, res_next;
    logic               sq_ge;

    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic [ITW-1:0]     iter_reg;
    logic signed [33:0] sh_x, sh_y, atan_v, nx, ny, nz;
    logic               rot_pos;

    logic [51:0]        dq_reg, dq_next;
    logic [23:0]        drem_reg, drem_next;
    logic [24:0]        d_shift;
    logic               d_ge;
    logic [5:0]         dcnt_reg;
    logic               dneg_reg;
    logic [51:0]        prod_mag;
    logic signed [31:0] rate_v;

    logic signed [32:0] wheel_diff;
    logic signed [67:0] arg_full;
    logic signed [33:0] avg_v, zang, c_val, s_val;

    logic               s_accept, out_load, m_valid_reg;
    logic signed [31:0] m_pos_x_reg, m_pos_y_reg, m_lin_reg, m_ang_reg;
    logic signed [30:0] m_heading_reg;
    logic               m_rej_reg;

    assign s_ready  = (state_reg == ddo_pkg::ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_load = (state_reg == ddo_pkg::ST_OUT) && (!m_valid_reg || m_ready);

    assign m_valid        = m_valid_reg;
    assign m_pos_x        = m_pos_x_reg;
    assign m_pos_y        = m_pos_y_reg;
    assign m_heading      = m_heading_reg;
    assign m_linear_speed = m_lin_reg;
    assign m_turn_rate    = m_ang_reg;
    assign m_rejected     = m_rej_reg;

    // shared datapath helpers
    assign wheel_diff = 33'(right_reg) - 33'(left_reg);
    assign arg_full   = (prod_reg + 68'sd8) >>> 4;
    assign c_val      = neg_reg ? -cx_reg : cx_reg;
    assign s_val      = neg_reg ? -cy_reg : cy_reg;
    assign avg_v      = ddo_pkg::wrap_once(34'(turn_reg >>> 1) + 34'(cur_yaw_reg));
    assign zang       = avg_v <<< 2;
    assign prod_mag   = prod_reg[67] ? 52'(-prod_reg) : prod_reg[51:0];

    // square root digit step
    assign sq_sum   = res_reg + bit_reg;
    assign sq_ge    = rem_reg >= sq_sum;
    assign res_next = sq_ge ? ((res_reg >> 1) + bit_reg) : (res_reg >> 1);

    // CORDIC stage: vectoring drives y to zero, rotation drives z to zero
    assign sh_x    = cx_reg >>> iter_reg;
    assign sh_y    = cy_reg >>> iter_reg;
    assign atan_v  = ddo_pkg::atan_q30(5'(iter_reg));
    assign rot_pos = (state_reg == ddo_pkg::ST_VEC) ? cy_reg[33] : !cz_reg[33];
    assign nx      = rot_pos ? cx_reg - sh_y : cx_reg + sh_y;
    assign ny      = rot_pos ? cy_reg + sh_x : cy_reg - sh_x;
    assign nz      = rot_pos ? cz_reg - atan_v : cz_reg + atan_v;

    // restoring divider step
    assign d_shift   = {drem_reg, dq_reg[51]};
    assign d_ge      = d_shift >= {1'b0, dt_reg};
    assign drem_next = d_ge ? 24'(d_shift - {1'b0, dt_reg}) : d_shift[23:0];
    assign dq_next   = {dq_reg[50:0], d_ge};

    always_comb begin
        if (dt_reg == 24'd0) begin
            rate_v = 32'sd0;
        end else if (state_reg == ddo_pkg::ST_ADIV) begin
            rate_v = ddo_pkg::rate_sat(dq_next >> 12, dneg_reg);
        end else begin
            rate_v = ddo_pkg::rate_sat(dq_next, dneg_reg);
        end
    end

    // multiplier operand select
    always_comb begin
        case (state_reg)
            ddo_pkg::ST_SMUL: begin
                mul_a = 34'(ticks_reg);
                mul_b = $signed({2'b0, mpt_reg});
            end
            ddo_pkg::ST_ARG_MUL: begin
                mul_a = 34'(wheel_diff);
                mul_b = $signed({10'b0, iwb_reg});
            end
            ddo_pkg::ST_SQ_MUL: begin
                mul_a = 34'(arg_reg);
                mul_b = 34'(arg_reg);
            end
            ddo_pkg::ST_XMUL: begin
                mul_a = c_val;
                mul_b = 34'(dist_reg);
            end
            ddo_pkg::ST_XADD: begin
                mul_a = s_val;
                mul_b = 34'(dist_reg);
            end
            ddo_pkg::ST_YADD: begin
                mul_a = 34'(dist_reg);
                mul_b = ddo_pkg::US_PER_S;
            end
            default: begin
                mul_a = 34'(turn_reg);
                mul_b = ddo_pkg::US_PER_S;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ddo_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ddo_pkg::ST_IDLE: begin
                if (s_accept) begin
                    case (ddo_pkg::op_t'(s_operation))
                        ddo_pkg::OP_LEFT: begin
                            if (s_encoder_count != 32'sd0 && prev_left_reg != 32'd0) begin
                                state_next = ddo_pkg::ST_SMUL;
                            end
                        end
                        ddo_pkg::OP_RIGHT: begin
                            if (s_encoder_count != 32'sd0 && prev_right_reg != 32'd0) begin
                                state_next = ddo_pkg::ST_SMUL;
                            end
                        end
                        ddo_pkg::OP_TICK: begin
                            if (pose_loaded_reg) begin
                                state_next = ddo_pkg::ST_ARG_MUL;
                            end
                        end
                        default: state_next = ddo_pkg::ST_IDLE;
                    endcase
                end
            end
            ddo_pkg::ST_SMUL:    state_next = ddo_pkg::ST_SSAT;
            ddo_pkg::ST_SSAT:    state_next = ddo_pkg::ST_IDLE;
            ddo_pkg::ST_ARG_MUL: state_next = ddo_pkg::ST_ARG_CHK;
            ddo_pkg::ST_ARG_CHK: begin
                if (arg_full > 68'(ddo_pkg::ONE_Q28) || arg_full < -68'(ddo_pkg::ONE_Q28)) begin
                    state_next = ddo_pkg::ST_OUT;
                end else begin
                    state_next = ddo_pkg::ST_SQ_MUL;
                end
            end
            ddo_pkg::ST_SQ_MUL:  state_next = ddo_pkg::ST_SQ_INIT;
            ddo_pkg::ST_SQ_INIT: state_next = ddo_pkg::ST_SQRT;
            ddo_pkg::ST_SQRT: begin
                if (bit_reg[0]) begin
                    state_next = ddo_pkg::ST_VEC;
                end
            end
            ddo_pkg::ST_VEC: begin
                if (iter_reg == ITER_LAST) begin
                    state_next = ddo_pkg::ST_TURN;
                end
            end
            ddo_pkg::ST_TURN:     state_next = ddo_pkg::ST_ROT_PREP;
            ddo_pkg::ST_ROT_PREP: state_next = ddo_pkg::ST_ROT;
            ddo_pkg::ST_ROT: begin
                if (iter_reg == ITER_LAST) begin
                    state_next = ddo_pkg::ST_XMUL;
                end
            end
            ddo_pkg::ST_XMUL:  state_next = ddo_pkg::ST_XADD;
            ddo_pkg::ST_XADD:  state_next = ddo_pkg::ST_YADD;
            ddo_pkg::ST_YADD:  state_next = ddo_pkg::ST_LINIT;
            ddo_pkg::ST_LINIT: state_next = ddo_pkg::ST_LDIV;
            ddo_pkg::ST_LDIV: begin
                if (dcnt_reg == 6'd51) begin
                    state_next = ddo_pkg::ST_ADIV;
                end
            end
            ddo_pkg::ST_ADIV: begin
                if (dcnt_reg == 6'd51) begin
                    state_next = ddo_pkg::ST_OUT;
                end
            end
            ddo_pkg::ST_OUT: begin
                if (out_load) begin
                    state_next = ddo_pkg::ST_IDLE;
                end
            end
            default: state_next = ddo_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (!aresetn) begin
            mpt_reg         <= ddo_pkg::MPT_RESET;
            iwb_reg         <= ddo_pkg::IWB_RESET;
            prev_left_reg   <= '0;
            prev_right_reg  <= '0;
            left_reg        <= '0;
            right_reg       <= '0;
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            cur_yaw_reg     <= '0;
            pose_loaded_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == ddo_pkg::CFG_IWB) begin
                    iwb_reg <= cfg_wdata[23:0];
                end else begin
                    mpt_reg <= cfg_wdata;
                end
            end
            if (m_valid_reg && m_ready && !out_load) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ddo_pkg::ST_IDLE: begin
                    if (s_accept) begin
                        dt_reg <= s_elapsed_us;
                        case (ddo_pkg::op_t'(s_operation))
                            ddo_pkg::OP_LEFT: begin
                                ticks_reg     <= s_encoder_count - $signed(prev_left_reg);
                                side_reg      <= 1'b0;
                                prev_left_reg <= s_encoder_count;
                            end
                            ddo_pkg::OP_RIGHT: begin
                                ticks_reg      <= s_encoder_count - $signed(prev_right_reg);
                                side_reg       <= 1'b1;
                                prev_right_reg <= s_encoder_count;
                            end
                            ddo_pkg::OP_POSE: begin
                                cur_x_reg       <= s_pose_x;
                                cur_y_reg       <= s_pose_y;
                                cur_yaw_reg     <= s_pose_yaw;
                                pose_loaded_reg <= 1'b1;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ddo_pkg::ST_SSAT: begin
                    if (side_reg) begin
                        right_reg <= ddo_pkg::sat32((prod_reg + RND16) >>> 16);
                    end else begin
                        left_reg <= ddo_pkg::sat32((prod_reg + RND16) >>> 16);
                    end
                end
                ddo_pkg::ST_ARG_MUL: begin
                    dist_reg <= 32'((33'(left_reg) + 33'(right_reg)) >>> 1);
                end
                ddo_pkg::ST_ARG_CHK: begin
                    arg_reg <= arg_full[29:0];
                    if (arg_full > 68'(ddo_pkg::ONE_Q28) || arg_full < -68'(ddo_pkg::ONE_Q28)) begin
                        // turn out of range: hold position, wrap yaw, zero speeds
                        rej_reg     <= 1'b1;
                        lin_reg     <= '0;
                        ang_reg     <= '0;
                        cur_yaw_reg <= 31'(ddo_pkg::wrap_once(34'(cur_yaw_reg)));
                    end else begin
                        rej_reg <= 1'b0;
                    end
                end
                ddo_pkg::ST_SQ_INIT: begin
                    rem_reg <= (58'd1 << 56) - prod_reg[57:0];
                    res_reg <= '0;
                    bit_reg <= 58'd1 << 56;
                end
                ddo_pkg::ST_SQRT: begin
                    if (sq_ge) begin
                        rem_reg <= rem_reg - sq_sum;
                    end
                    res_reg <= res_next;
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg[0]) begin
                        cx_reg   <= $signed({res_next[31:0], 2'b00});
                        cy_reg   <= 34'(arg_reg) <<< 2;
                        cz_reg   <= '0;
                        iter_reg <= '0;
                    end
                end
                ddo_pkg::ST_VEC, ddo_pkg::ST_ROT: begin
                    cx_reg   <= nx;
                    cy_reg   <= ny;
                    cz_reg   <= nz;
                    iter_reg <= iter_reg + 1'b1;
                end
                ddo_pkg::ST_TURN: begin
                    turn_reg <= 32'((cz_reg + 34'sd2) >>> 2);
                end
                ddo_pkg::ST_ROT_PREP: begin
                    // fold the mid heading into +-pi/2, negate results afterwards
                    if (zang > ddo_pkg::HALF_PI_Q30) begin
                        cz_reg  <= zang - ddo_pkg::PI_Q30;
                        neg_reg <= 1'b1;
                    end else if (zang < -ddo_pkg::HALF_PI_Q30) begin
                        cz_reg  <= zang + ddo_pkg::PI_Q30;
                        neg_reg <= 1'b1;
                    end else begin
                        cz_reg  <= zang;
                        neg_reg <= 1'b0;
                    end
                    cx_reg   <= ddo_pkg::GAIN_Q30;
                    cy_reg   <= '0;
                    iter_reg <= '0;
                end
                ddo_pkg::ST_XADD: begin
                    cur_x_reg <= ddo_pkg::sat32(68'(cur_x_reg) + ((prod_reg + RND30) >>> 30));
                end
                ddo_pkg::ST_YADD: begin
                    cur_y_reg   <= ddo_pkg::sat32(68'(cur_y_reg) + ((prod_reg + RND30) >>> 30));
                    cur_yaw_reg <= 31'(ddo_pkg::wrap_once(34'(turn_reg) + 34'(cur_yaw_reg)));
                end
                ddo_pkg::ST_LINIT: begin
                    dq_reg   <= prod_mag;
                    dneg_reg <= prod_reg[67];
                    drem_reg <= '0;
                    dcnt_reg <= '0;
                end
                ddo_pkg::ST_LDIV: begin
                    if (dcnt_reg == 6'd51) begin
                        // product now holds turn * 1e6 for the angular rate
                        lin_reg  <= rate_v;
                        dq_reg   <= prod_mag;
                        dneg_reg <= prod_reg[67];
                        drem_reg <= '0;
                        dcnt_reg <= '0;
                    end else begin
                        dq_reg   <= dq_next;
                        drem_reg <= drem_next;
                        dcnt_reg <= dcnt_reg + 6'd1;
                    end
                end
                ddo_pkg::ST_ADIV: begin
                    dq_reg   <= dq_next;
                    drem_reg <= drem_next;
                    dcnt_reg <= dcnt_reg + 6'd1;
                    if (dcnt_reg == 6'd51) begin
                        ang_reg <= rate_v;
                    end
                end
                ddo_pkg::ST_OUT: begin
                    if (out_load) begin
                        m_valid_reg   <= 1'b1;
                        m_pos_x_reg   <= cur_x_reg;
                        m_pos_y_reg   <= cur_y_reg;
                        m_heading_reg <= cur_yaw_reg;
                        m_lin_reg     <= lin_reg;
                        m_ang_reg     <= ang_reg;
                        m_rej_reg     <= rej_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

/* dv/tb_diff_drive_odometry.sv */
// Self-checking testbench for diff_drive_odometry: directed and random requests,
// with a built-in pose integrator that predicts each tick result.
// Depends on rtl/ddo_pkg.sv and rtl/diff_drive_odometry.sv.
module tb_diff_drive_odometry;

    localparam int STEPS = 24;
    localparam int SETTLE = 250;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam longint PI_28 = 843314857;
    localparam longint TWO_PI_28 = 1686629713;
    localparam longint PI_30 = 64'd3373259426;
    localparam longint HALF_PI_30 = 1686629713;
    localparam longint ONE_28 = 268435456;

    typedef struct {
        ddo_pkg::op_t op;
        logic [31:0] cnt;
        logic [31:0] px;
        logic [31:0] py;
        logic [30:0] pyaw;
        logic [23:0] dt;
    } odo_req_t;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [30:0] hdg;
        logic [31:0] lin;
        logic [31:0] ang;
        logic        rej;
    } pose_out_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_operation = '0;
    logic signed [31:0] s_encoder_count = '0;
    logic signed [31:0] s_pose_x = '0;
    logic signed [31:0] s_pose_y = '0;
    logic signed [30:0] s_pose_yaw = '0;
    logic [23:0] s_elapsed_us = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_pos_x, m_pos_y, m_linear_speed, m_turn_rate;
    logic signed [30:0] m_heading;
    logic m_rejected;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [31:0] cfg_wdata = '0;

    diff_drive_odometry u_dut (.*);

    initial begin
        forever #4 aclk = ~aclk;
    end

    odo_req_t  pending_reqs[$];
    pose_out_t pose_expected[$];
    int        errors = 0;
    longint    cycles = 0;
    bit        idling = 1'b1;
    bit        hold_req = 1'b0;
    bit        took = 1'b0;
    int        src_gap = 0;
    int        sink_gap = 0;
    int        hold_left = 0;

    // predictor state and configuration
    logic [31:0] mpt, iwb;
    logic [31:0] last_left, last_right;
    logic signed [31:0] travel_l, travel_r, px_q, py_q, yaw_q;
    bit          pose_valid;

    longint arctan[32] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h3FFF, 64'h1FFF, 64'hFFF, 64'h7FF, 64'h3FF, 64'h1FF,
        64'hFF, 64'h7F, 64'h3F, 64'h1F, 64'hF, 64'h7, 64'h3, 64'h1, 64'h0, 64'h0};

    function automatic longint rnd_shr(longint v, int sh);
        return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint wrap_pi(longint v);
        if (v > PI_28) return v - TWO_PI_28;
        if (v < -PI_28) return v + TWO_PI_28;
        return v;
    endfunction

    function automatic logic signed [31:0] speed(longint num, longint unsigned den);
        longint unsigned mag;
        longint q;
        if (den == 0) return 0;
        mag = num < 0 ? longint'(-num) : longint'(num);
        q = longint'(mag / den);
        return clamp32(num < 0 ? -q : q);
    endfunction

    function automatic longint unsigned sqrt_floor(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // asin via vectoring on (sqrt(1-a^2), a); a in Q4.28, result Q2.30
    function automatic longint turn_angle(longint a);
        longint vx, vy, z, nx;
        vx = longint'(sqrt_floor((64'd1 << 56) - longint'(a * a))) * 4;
        vy = a * 4;
        z = 0;
        for (int i = 0; i < STEPS; i++) begin
            if (vy >= 0) begin
                nx = vx + (vy >>> i); vy = vy - (vx >>> i); z += arctan[i];
            end else begin
                nx = vx - (vy >>> i); vy = vy + (vx >>> i); z -= arctan[i];
            end
            vx = nx;
        end
        return z;
    endfunction

    task automatic rotate(input longint ang, output longint c, output longint s);
        longint z, vx, vy, nx;
        bit flip;
        z = ang * 4;
        vx = 652032874;
        vy = 0;
        flip = 0;
        if (z > HALF_PI_30) begin
            z -= PI_30; flip = 1;
        end else if (z < -HALF_PI_30) begin
            z += PI_30; flip = 1;
        end
        for (int i = 0; i < STEPS; i++) begin
            if (z >= 0) begin
                nx = vx - (vy >>> i); vy = vy + (vx >>> i); z -= arctan[i];
            end else begin
                nx = vx + (vy >>> i); vy = vy - (vx >>> i); z += arctan[i];
            end
            vx = nx;
        end
        c = flip ? -vx : vx;
        s = flip ? -vy : vy;
    endtask

    task automatic wheel_sample(input logic [31:0] cnt, inout logic [31:0] last,
                                inout logic signed [31:0] trav);
        longint ticks;
        if (cnt != 0 && last != 0) begin
            ticks = longint'($signed(cnt - last));
            trav = clamp32(rnd_shr(ticks * longint'(mpt), 16));
        end
        last = cnt;
    endtask

    task automatic integrate(input odo_req_t r);
        longint d, arg, turn, mid, c, s, yaw;
        pose_out_t o;
        o.lin = 0;
        o.ang = 0;
        o.rej = 0;
        case (r.op)
            ddo_pkg::OP_LEFT: wheel_sample(r.cnt, last_left, travel_l);
            ddo_pkg::OP_RIGHT: wheel_sample(r.cnt, last_right, travel_r);
            ddo_pkg::OP_POSE: begin
                px_q = r.px;
                py_q = r.py;
                yaw_q = {r.pyaw[30], r.pyaw};
                pose_valid = 1;
            end
            ddo_pkg::OP_TICK: if (pose_valid) begin
                d = (longint'(travel_l) + longint'(travel_r)) >>> 1;
                arg = rnd_shr((longint'(travel_r) - longint'(travel_l)) * longint'(iwb), 4);
                if (arg > ONE_28 || arg < -ONE_28) begin
                    o.rej = 1;
                    yaw = wrap_pi(longint'(yaw_q));
                end else begin
                    turn = rnd_shr(turn_angle(arg), 2);
                    mid = wrap_pi((turn >>> 1) + longint'(yaw_q));
                    rotate(mid, c, s);
                    px_q = clamp32(longint'(px_q) + rnd_shr(c * d, 30));
                    py_q = clamp32(longint'(py_q) + rnd_shr(s * d, 30));
                    yaw = wrap_pi(turn + longint'(yaw_q));
                    o.lin = speed(d * 1000000, longint'(r.dt));
                    o.ang = speed(turn * 1000000, longint'(r.dt) * 4096);
                end
                yaw_q = yaw[31:0];
                o.x = px_q;
                o.y = py_q;
                o.hdg = yaw_q[30:0];
                pose_expected.push_back(o);
            end
            default: ;
        endcase
    endtask

    // request acceptance and prediction
    always @(posedge aclk) begin
        odo_req_t r;
        took <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            r = pending_reqs.pop_front();
            integrate(r);
        end
    end

    // sender
    always @(negedge aclk) begin
        odo_req_t r;
        if (aresetn && !(s_valid && !took)) begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_valid <= 1'b0;
            end else if (idling && took && $urandom_range(0, 5) == 0) begin
                src_gap <= $urandom_range(0, 3);
                s_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                r = pending_reqs[0];
                s_valid <= 1'b1;
                s_operation <= r.op;
                s_encoder_count <= r.cnt;
                s_pose_x <= r.px;
                s_pose_y <= r.py;
                s_pose_yaw <= r.pyaw;
                s_elapsed_us <= r.dt;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off on request
    always @(negedge aclk) begin
        if (hold_req && hold_left == 0) begin
            hold_left <= 3000;
            m_ready <= 1'b0;
        end else if (hold_left > 1) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            m_ready <= 1'b0;
        end else if (idling && $urandom_range(0, 7) == 0) begin
            sink_gap <= $urandom_range(0, 3);
            m_ready <= 1'b0;
        end else begin
            if (hold_left == 1) hold_left <= -1;
            m_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        pose_out_t e;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            if (pose_expected.size() == 0) begin
                errors <= errors + 1;
                if (errors < 10) $display("unexpected result x=%0d y=%0d", m_pos_x, m_pos_y);
            end else begin
                e = pose_expected.pop_front();
                if (e.x !== m_pos_x || e.y !== m_pos_y || e.hdg !== m_heading ||
                    e.lin !== m_linear_speed || e.ang !== m_turn_rate ||
                    e.rej !== m_rejected) begin
                    errors <= errors + 1;
                    if (errors < 10)
                        $display("mismatch exp x=%0d y=%0d h=%0d v=%0d w=%0d r=%0d / got x=%0d y=%0d h=%0d v=%0d w=%0d r=%0d",
                                 $signed(e.x), $signed(e.y), $signed(e.hdg), $signed(e.lin),
                                 $signed(e.ang), e.rej, m_pos_x, m_pos_y, m_heading,
                                 m_linear_speed, m_turn_rate, m_rejected);
                end
            end
        end
    end

    task automatic add(input ddo_pkg::op_t op, input logic [31:0] cnt, input logic [31:0] px,
                       input logic [31:0] py, input logic [30:0] pyaw, input logic [23:0] dt);
        odo_req_t r;
        r.op = op; r.cnt = cnt; r.px = px; r.py = py; r.pyaw = pyaw; r.dt = dt;
        pending_reqs.push_back(r);
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || s_valid || pose_expected.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == ddo_pkg::CFG_MPT) mpt = val;
        else iwb = {8'd0, val[23:0]};
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [30:0] rand_yaw();
        longint v;
        v = longint'($urandom_range(0, 1686629714)) - PI_28;
        return v[30:0];
    endfunction

    function automatic logic [23:0] rand_dt();
        case ($urandom_range(0, 9))
            0: return 24'd0;
            1: return 24'($urandom());
            default: return 24'($urandom_range(1, 200000));
        endcase
    endfunction

    initial begin
        logic [31:0] lc, rc;
        int n;
        mpt = ddo_pkg::MPT_RESET;
        iwb = {8'd0, ddo_pkg::IWB_RESET};
        last_left = 0; last_right = 0;
        travel_l = 0; travel_r = 0;
        px_q = 0; py_q = 0; yaw_q = 0;
        pose_valid = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: tick before pose, zero counts, extremes, zero time, rejection
        add(ddo_pkg::OP_TICK, 0, 0, 0, 0, 1000);
        add(ddo_pkg::OP_LEFT, 0, 0, 0, 0, 0);
        add(ddo_pkg::OP_RIGHT, 0, 0, 0, 0, 0);
        add(ddo_pkg::OP_POSE, 0, 32'h7FFFFFFF, 32'h80000000, 31'(PI_28), 0);
        add(ddo_pkg::OP_TICK, 0, 0, 0, 0, 0);
        add(ddo_pkg::OP_LEFT, 1000, 0, 0, 0, 0);
        add(ddo_pkg::OP_RIGHT, 1000, 0, 0, 0, 0);
        add(ddo_pkg::OP_LEFT, 1100, 0, 0, 0, 0);
        add(ddo_pkg::OP_RIGHT, 1150, 0, 0, 0, 0);
        add(ddo_pkg::OP_TICK, 0, 0, 0, 0, 50000);
        add(ddo_pkg::OP_LEFT, 32'h7FFFFFFF, 0, 0, 0, 0);
        add(ddo_pkg::OP_RIGHT, 32'h80000000, 0, 0, 0, 0);
        add(ddo_pkg::OP_TICK, 0, 0, 0, 0, 24'hFFFFFF);
        add(ddo_pkg::OP_POSE, 0, 0, 0, 31'(-PI_28), 0);
        add(ddo_pkg::OP_LEFT, 32'hFFFFFFFF, 0, 0, 0, 0);
        add(ddo_pkg::OP_RIGHT, 32'h7FFFFF00, 0, 0, 0, 0);
        add(ddo_pkg::OP_TICK, 0, 0, 0, 0, 1);
        add(ddo_pkg::OP_LEFT, 32'hFFFFFFFE, 0, 0, 0, 0);
        add(ddo_pkg::OP_RIGHT, 32'h7FFFFF01, 0, 0, 0, 0);
        add(ddo_pkg::OP_TICK, 0, 0, 0, 0, 1);
        add(ddo_pkg::OP_POSE, 0, 32'h00010000, 32'hFFFF0000,
            31'h7FFFFFFF & 31'(PI_28 - 5), 0);
        add(ddo_pkg::OP_TICK, 0, 0, 0, 0, 24'h000001);
        wait_idle();

        lc = 32'd5000;
        rc = 32'd7000;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                1: begin
                    write_cfg(ddo_pkg::CFG_MPT, 32'hFFFFFFFF);
                    write_cfg(ddo_pkg::CFG_IWB, 32'd1);
                end
                2: begin
                    write_cfg(ddo_pkg::CFG_MPT, 32'd1);
                    write_cfg(ddo_pkg::CFG_IWB, 32'h00FFFFFF);
                end
                3: begin
                    write_cfg(ddo_pkg::CFG_MPT, $urandom());
                    write_cfg(ddo_pkg::CFG_IWB, $urandom_range(1, 600000));
                end
                4: begin
                    write_cfg(ddo_pkg::CFG_MPT, ddo_pkg::MPT_RESET);
                    write_cfg(ddo_pkg::CFG_IWB, {8'd0, ddo_pkg::IWB_RESET});
                end
                default: ;
            endcase
            if (phase == 4) idling = 1'b0;
            // one long receiver hold-off while this phase streams in
            if (phase == 0) hold_req = 1'b1;
            add(ddo_pkg::OP_POSE, 0, $urandom(), $urandom(), rand_yaw(), 0);
            n = 0;
            while (n < 130) begin
                if ($urandom_range(0, 9) < 8) begin
                    // well-formed: both wheels advance a little, then a tick
                    lc = lc + $urandom_range(0, 400) - 100;
                    rc = rc + $urandom_range(0, 400) - 100;
                    if (lc == 0) lc = 1;
                    if (rc == 0) rc = 1;
                    add(ddo_pkg::OP_LEFT, lc, $urandom(), $urandom(), rand_yaw(),
                        24'($urandom()));
                    add(ddo_pkg::OP_RIGHT, rc, $urandom(), $urandom(), rand_yaw(),
                        24'($urandom()));
                    add(ddo_pkg::OP_TICK, $urandom(), $urandom(), $urandom(), rand_yaw(),
                        rand_dt());
                    n += 3;
                end else begin
                    case ($urandom_range(0, 3))
                        0: add(ddo_pkg::OP_POSE, $urandom(), $urandom(), $urandom(),
                               rand_yaw(), 24'($urandom()));
                        1: begin lc = $urandom(); add(ddo_pkg::OP_LEFT, lc, 0, 0, 0, 0); end
                        2: begin rc = $urandom(); add(ddo_pkg::OP_RIGHT, rc, 0, 0, 0, 0); end
                        default: add(ddo_pkg::OP_TICK, 0, 0, 0, 0, rand_dt());
                    endcase
                    n += 1;
                end
            end
            wait_idle();
        end

        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
